FILE: rtl/dlbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlbs_pkg: shared types and helpers for the dual LED bar graph shifter
// Frame geometry, queue entry type and the half-frame pattern builder.
// ----------------------------------------------------------------------------
package dlbs_pkg;

    localparam int CHAIN_BYTES = 8;
    localparam int FRAME_W     = CHAIN_BYTES * 8;
    localparam int HALF_W      = FRAME_W / 2;
    localparam int CNT_W       = $clog2(FRAME_W);
    localparam int LEVEL_W     = 5;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL = 5'd30;

    localparam logic ACT_BATTERY = 1'b0;
    localparam logic ACT_POWER   = 1'b1;

    // One pending frame update: which half, and its new contents
    typedef struct packed {
        logic              action;
        logic [HALF_W-1:0] half;
    } upd_t;

    function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] lv);
        sat_level = (lv > MAX_LEVEL) ? MAX_LEVEL : lv;
    endfunction

    // Bar position p lives in byte p/8 at bit 7-(p%8); byte 0 of the half is bits 7:0
    function automatic logic [HALF_W-1:0] build_half(
        input logic               action,
        input logic [LEVEL_W-1:0] lv,
        input logic               hot
    );
        logic [HALF_W-1:0] h;
        logic [5:0]        lv_ext;
        logic [5:0]        pp;
        logic              lit;
        h      = '0;
        lv_ext = {1'b0, lv};
        for (int p = 0; p < HALF_W; p++) begin
            pp = 6'(p);
            if (action == ACT_BATTERY) begin
                lit = (p < HALF_W - 2) ? (pp < lv_ext) : hot;
            end
            else begin
                lit = (p < 2) ? hot : (pp < lv_ext + 6'd2);
            end
            h[(p / 8) * 8 + 7 - (p % 8)] = lit;
        end
        build_half = h;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/dlbs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlbs_front: request filter
// Saturates the level, drops items that repeat the stored level, and queues
// the new half-frame for the others.
// ----------------------------------------------------------------------------
module dlbs_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        action,
    input  wire logic [dlbs_pkg::LEVEL_W-1:0] level,
    input  wire logic                        overheat_flag,
    output logic                             push_valid,
    input  wire logic                        push_ready,
    output dlbs_pkg::upd_t                   push_data
);

    logic [dlbs_pkg::LEVEL_W-1:0] bat_reg, bat_next;
    logic [dlbs_pkg::LEVEL_W-1:0] pwr_reg, pwr_next;
    logic [dlbs_pkg::LEVEL_W-1:0] lv_sat;
    logic                         same;
    logic                         accept;

    always_comb
    begin
        lv_sat = dlbs_pkg::sat_level(level);
        same   = (action == dlbs_pkg::ACT_BATTERY) ? (lv_sat == bat_reg)
                                                   : (lv_sat == pwr_reg);
        in_ready   = push_ready;
        accept     = in_valid && push_ready;
        push_valid = in_valid && !same;
        push_data.action = action;
        push_data.half   = dlbs_pkg::build_half(action, lv_sat, overheat_flag);
        bat_next = bat_reg;
        pwr_next = pwr_reg;
        if (accept && !same) begin
            if (action == dlbs_pkg::ACT_BATTERY) begin
                bat_next = lv_sat;
            end
            else begin
                pwr_next = lv_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bat_reg <= '0;
            pwr_reg <= '0;
        end
        else begin
            bat_reg <= bat_next;
            pwr_reg <= pwr_next;
        end
    end

    // A queued battery update records its level in the battery register
    a_level_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready && action == dlbs_pkg::ACT_BATTERY)
        |=> bat_reg == $past(lv_sat))
        else $error("battery level not recorded");

endmodule
`default_nettype wire

FILE: rtl/dlbs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlbs_queue: two-entry update queue
// Decouples the request filter from the frame shifter.
// ----------------------------------------------------------------------------
module dlbs_queue (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push_valid,
    output logic         push_ready,
    input  wire dlbs_pkg::upd_t push_data,
    output logic         pop_valid,
    input  wire logic    pop_ready,
    output dlbs_pkg::upd_t pop_data
);

    dlbs_pkg::upd_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_push, do_pop;

    always_comb
    begin
        push_ready  = (count_reg != 2'd2);
        pop_valid   = (count_reg != 2'd0);
        pop_data    = mem_reg[rd_ptr_reg];
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue overflow");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step");

endmodule
`default_nettype wire

FILE: rtl/dlbs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlbs_back: frame store and serializer
// Applies one queued half update to the frame, then shifts all 64 bits out.
// ----------------------------------------------------------------------------
module dlbs_back (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      pop_valid,
    output logic           pop_ready,
    input  wire dlbs_pkg::upd_t pop_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic           serial_bit,
    output logic           latch_last
);

    localparam logic [dlbs_pkg::CNT_W-1:0] LAST_CNT = dlbs_pkg::CNT_W'(dlbs_pkg::FRAME_W - 1);

    logic [dlbs_pkg::FRAME_W-1:0] frame_reg, frame_next;
    logic [dlbs_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         ov_reg, ov_next;
    logic                         bit_reg, bit_next;
    logic                         last_reg, last_next;
    logic                         can_load;
    logic [dlbs_pkg::CNT_W-1:0]   idx;

    always_comb
    begin
        frame_next = frame_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        ov_next    = ov_reg;
        bit_next   = bit_reg;
        last_next  = last_reg;
        can_load   = !ov_reg || out_ready;
        pop_ready  = !busy_reg;
        // bytes go out in pairs swapped (1,0,3,2,...), each LSB first
        idx = {cnt_reg[dlbs_pkg::CNT_W-1:3] ^ 3'd1, cnt_reg[2:0]};

        if (!busy_reg) begin
            if (pop_valid) begin
                if (pop_data.action == dlbs_pkg::ACT_BATTERY) begin
                    frame_next[dlbs_pkg::HALF_W-1:0] = pop_data.half;
                end
                else begin
                    frame_next[dlbs_pkg::FRAME_W-1:dlbs_pkg::HALF_W] = pop_data.half;
                end
                busy_next = 1'b1;
                cnt_next  = '0;
            end
            if (out_ready) begin
                ov_next = 1'b0;
            end
        end
        else if (can_load) begin
            ov_next   = 1'b1;
            bit_next  = frame_reg[idx];
            last_next = (cnt_reg == LAST_CNT);
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LAST_CNT) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_reg <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else begin
            frame_reg <= frame_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg  <= bit_next;
        last_reg <= last_next;
    end

    assign out_valid  = ov_reg;
    assign serial_bit = bit_reg;
    assign latch_last = last_reg;

    a_end_of_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && can_load && cnt_reg == LAST_CNT) |=> (!busy_reg && latch_last))
        else $error("frame end not marked");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg != LAST_CNT && can_load) |=> busy_reg)
        else $error("shift stopped early");

endmodule
`default_nettype wire

FILE: rtl/dual_led_bar_graph_shifter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_led_bar_graph_shifter: two 32-LED bars on a 64-bit shift chain
// Keeps the LED frame and each bar's level; a level change rewrites that
// bar's half and streams the whole frame out one bit per item.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | input     | in_valid / in_ready   | action, level, overheat_flag
//  out     | output    | out_valid / out_ready | serial_bit, latch_last
//
//  A level change yields 64 output items, one per clock when out_ready stays
//  high; the serializer first loads the frame, then shifts it out and takes no
//  new update until its bit counter has passed the last bit.
//  An item that repeats the stored level is taken when the queue has room and yields nothing.
//  Reset clears the frame and both stored levels.
//  A two-entry queue sits between filter and serializer, so input keeps
//  flowing while output stalls until the queue fills.
//
module dual_led_bar_graph_shifter (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         action,
    input  wire logic [dlbs_pkg::LEVEL_W-1:0] level,
    input  wire logic                         overheat_flag,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              serial_bit,
    output logic                              latch_last
);

    // filter -> queue
    logic           push_valid;
    logic           push_ready;
    dlbs_pkg::upd_t push_data;

    // queue -> serializer
    logic           pop_valid;
    logic           pop_ready;
    dlbs_pkg::upd_t pop_data;

    // Drop repeats and build the new half-frame
    dlbs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .level         (level),
        .overheat_flag (overheat_flag),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    // Hold pending updates while the serializer is busy
    dlbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Merge the update into the frame and shift it out
    dlbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .serial_bit (serial_bit),
        .latch_last (latch_last)
    );

endmodule
`default_nettype wire

FILE: tb/sv/tb_dual_led_bar_graph_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_led_bar_graph_shifter: self-checking bench for the LED bar shifter
// Drives bar level updates over the input handshake and keeps its own copy of
// the 64-LED frame and both stored levels. Each chain bit streamed out is
// checked in order against the predicted bit and latch flag.
// ----------------------------------------------------------------------------
module tb_dual_led_bar_graph_shifter;

    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 70;     // quiet time after the last owed bit, to catch stray output

    // One chain bit as it should leave the block
    typedef struct packed {
        bit serial;
        bit last;
    } chain_bit_t;

    // ------------------------------------------------------------------------
    // Scoreboard: frame predictor plus the queue of chain bits still owed
    // ------------------------------------------------------------------------
    class led_chain_scoreboard;
        bit [7:0]                   frame_bytes [dlbs_pkg::CHAIN_BYTES];
        bit [dlbs_pkg::LEVEL_W-1:0] battery_level;
        bit [dlbs_pkg::LEVEL_W-1:0] power_level;
        chain_bit_t                 owed_bits [$];
        int                         mismatches;
        int                         bits_checked;
        int                         battery_updates;
        int                         power_updates;
        int                         unchanged_items;
        int                         saturated_items;

        // Light or clear bar position p of the half that starts at byte base
        function void set_position(int base, int p, bit on);
            int byte_idx;
            int bit_idx;
            byte_idx = base + p / 8;
            bit_idx  = 7 - p % 8;
            frame_bytes[byte_idx][bit_idx] = on;
        endfunction

        function void note_item(bit act, bit [dlbs_pkg::LEVEL_W-1:0] lv_in, bit hot);
            bit [dlbs_pkg::LEVEL_W-1:0] lv;
            chain_bit_t                 cb;
            int                         n;
            if (lv_in > dlbs_pkg::MAX_LEVEL)
                saturated_items++;
            lv = (lv_in > dlbs_pkg::MAX_LEVEL) ? dlbs_pkg::MAX_LEVEL : lv_in;
            if (act == dlbs_pkg::ACT_BATTERY) begin
                if (lv == battery_level) begin
                    unchanged_items++;
                    return;
                end
                battery_level = lv;
                battery_updates++;
                for (int p = 0; p < 30; p++)
                    set_position(0, p, p < lv);
                set_position(0, 30, hot);
                set_position(0, 31, hot);
            end
            else begin
                if (lv == power_level) begin
                    unchanged_items++;
                    return;
                end
                power_level = lv;
                power_updates++;
                set_position(4, 0, hot);
                set_position(4, 1, hot);
                for (int p = 2; p < 32; p++)
                    set_position(4, p, p < int'(lv) + 2);
            end
            // Chain order swaps each byte pair (1,0,3,2,...), each byte LSB first
            n = 0;
            for (int b = 0; b < dlbs_pkg::CHAIN_BYTES; b++) begin
                for (int i = 0; i < 8; i++) begin
                    cb.serial = frame_bytes[b ^ 1][i];
                    cb.last   = (n == dlbs_pkg::CHAIN_BYTES * 8 - 1);
                    owed_bits.push_back(cb);
                    n++;
                end
            end
        endfunction

        function void check_bit(bit serial, bit last);
            chain_bit_t cb;
            if (owed_bits.size() == 0) begin
                $display("%0t: unexpected chain bit serial_bit=%0b latch_last=%0b",
                         $time, serial, last);
                mismatches++;
                return;
            end
            cb = owed_bits.pop_front();
            bits_checked++;
            if (serial != cb.serial) begin
                $display("%0t: serial_bit mismatch, expected %0b, actual %0b",
                         $time, cb.serial, serial);
                mismatches++;
            end
            if (last != cb.last) begin
                $display("%0t: latch_last mismatch, expected %0b, actual %0b",
                         $time, cb.last, last);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block I/O; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         in_valid      = 1'b0;
    logic                         in_ready;
    logic                         action        = 1'b0;
    logic [dlbs_pkg::LEVEL_W-1:0] level         = '0;
    logic                         overheat_flag = 1'b0;
    logic                         out_valid;
    logic                         out_ready     = 1'b0;
    logic                         serial_bit;
    logic                         latch_last;

    led_chain_scoreboard sb = new();

    bit steady_sender = 1'b0;     // set while the sender must not idle
    int cycle_count   = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    dual_led_bar_graph_shifter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .level         (level),
        .overheat_flag (overheat_flag),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .serial_bit    (serial_bit),
        .latch_last    (latch_last)
    );

    // Watchdog: abort a hung run well past the slowest legal one
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d chain bits still owed",
                     cycle_count, sb.owed_bits.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Check every chain bit taken at a rising edge, in arrival order
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_bit(serial_bit, latch_last);
    end

    // ------------------------------------------------------------------------
    // Receiver: stall about one cycle in ten, with a long stall-free window
    // and one long hold-off that backs the block up into its input
    // ------------------------------------------------------------------------
    initial
    begin
        int rx_cycles;
        rx_cycles = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            rx_cycles++;
            if (rx_cycles >= 5000 && rx_cycles < 5600)
                out_ready <= 1'b0;                   // hold off: let the queue fill
            else if (rx_cycles >= 15000 && rx_cycles < 21000)
                out_ready <= 1'b1;                   // no stalls at all
            else
                out_ready <= ($urandom_range(0, 99) >= 10);
        end
    end

    // ------------------------------------------------------------------------
    // Sender: offer one item, hold it until taken, then maybe idle a while.
    // Entered and left at a falling edge so valid drops between items only when the sender idles.
    // ------------------------------------------------------------------------
    task automatic offer_item(input bit act, input bit [dlbs_pkg::LEVEL_W-1:0] lv,
                              input bit hot);
        action        <= act;
        level         <= lv;
        overheat_flag <= hot;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(act, lv, hot);
        @(negedge clk);
        if (!steady_sender && $urandom_range(0, 99) < 10) begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < 30)
                @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int                         pick;
        bit                         act;
        bit [dlbs_pkg::LEVEL_W-1:0] lv;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset levels, both extremes, saturation, byte boundaries
        offer_item(dlbs_pkg::ACT_BATTERY, 5'd0,  1'b0);   // matches reset level: nothing out
        offer_item(dlbs_pkg::ACT_POWER,   5'd0,  1'b1);   // same for the power bar
        offer_item(dlbs_pkg::ACT_BATTERY, 5'd30, 1'b1);   // full battery bar with markers
        offer_item(dlbs_pkg::ACT_BATTERY, 5'd31, 1'b0);   // saturates to 30: unchanged
        offer_item(dlbs_pkg::ACT_POWER,   5'd31, 1'b1);   // saturates to 30: full power bar
        offer_item(dlbs_pkg::ACT_POWER,   5'd30, 1'b0);   // unchanged after saturation
        offer_item(dlbs_pkg::ACT_BATTERY, 5'd1,  1'b0);
        offer_item(dlbs_pkg::ACT_BATTERY, 5'd7,  1'b0);
        offer_item(dlbs_pkg::ACT_BATTERY, 5'd8,  1'b1);
        offer_item(dlbs_pkg::ACT_BATTERY, 5'd9,  1'b0);
        offer_item(dlbs_pkg::ACT_BATTERY, 5'd29, 1'b1);
        offer_item(dlbs_pkg::ACT_BATTERY, 5'd0,  1'b1);   // markers only, empty bar
        offer_item(dlbs_pkg::ACT_POWER,   5'd1,  1'b0);
        offer_item(dlbs_pkg::ACT_POWER,   5'd5,  1'b1);
        offer_item(dlbs_pkg::ACT_POWER,   5'd6,  1'b0);
        offer_item(dlbs_pkg::ACT_POWER,   5'd14, 1'b1);
        offer_item(dlbs_pkg::ACT_POWER,   5'd22, 1'b0);
        offer_item(dlbs_pkg::ACT_POWER,   5'd0,  1'b1);   // markers only on the power half
        offer_item(dlbs_pkg::ACT_BATTERY, 5'd16, 1'b0);
        offer_item(dlbs_pkg::ACT_BATTERY, 5'd16, 1'b1);   // same level, new flag: untouched
        offer_item(dlbs_pkg::ACT_BATTERY, 5'd31, 1'b1);
        offer_item(dlbs_pkg::ACT_POWER,   5'd31, 1'b0);

        // Random: mostly level changes, some repeats and saturating requests
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            steady_sender = (k >= 200 && k < 300);
            act  = 1'($urandom_range(0, 1));
            pick = int'($urandom_range(0, 99));
            if (pick < 10)
                lv = (act == dlbs_pkg::ACT_BATTERY) ? sb.battery_level : sb.power_level;
            else if (pick < 15)
                lv = dlbs_pkg::LEVEL_W'($urandom_range(30, 31));
            else
                lv = dlbs_pkg::LEVEL_W'($urandom_range(0, 31));
            offer_item(act, lv, 1'($urandom_range(0, 1)));
        end
        steady_sender = 1'b0;
        in_valid <= 1'b0;

        // Drain: wait for every owed bit, then watch for stray output
        while (sb.owed_bits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("frames: %0d battery and %0d power updates, %0d unchanged, %0d saturated",
                 sb.battery_updates, sb.power_updates, sb.unchanged_items,
                 sb.saturated_items);
        $display("chain bits checked: %0d, mismatches: %0d", sb.bits_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
